[rtl/core/lru_page_cache_directory_defines.svh]
// Assertion macros for the page cache directory.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef LRU_PAGE_CACHE_DIRECTORY_DEFINES_SVH
`define LRU_PAGE_CACHE_DIRECTORY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpcd assertion failed");

// Next-cycle implication, checked outside reset.
`define LPCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpcd assertion failed");

`endif

[rtl/core/lpcd_pkg.sv]
// Package for the page cache directory: command codes and item types.
// No dependencies; used by lru_page_cache_directory.
`default_nettype none

package lpcd_pkg;

    typedef enum logic [1:0] {
        CMD_GET     = 2'd0,
        CMD_NEW     = 2'd1,
        CMD_DIRTY   = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [7:0]  file_id;
        logic [31:0] page_ref;
        logic [3:0]  slot_sel;
    } req_item_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic        hit;
        logic        fetch_needed;
        logic        writeback;
        logic [7:0]  writeback_file;
        logic [31:0] writeback_page;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0]  file_id;
        logic [31:0] page_ref;
    } tag_t;

endpackage

`default_nettype wire

[rtl/core/lru_page_cache_directory.sv]
// Page cache directory with least-recently-used slot replacement.
// Depends on lpcd_pkg and lru_page_cache_directory_defines.svh.
//
// Usage: commands arrive on the req channel and results leave on the rsp
// channel, both valid/ready; an item moves when valid and ready are high.
// A get, new-page or mark-dirty item gives one result with last set. A
// release item gives one result per dirty slot of the file, then a final
// result with last set. The tag store is a single-port memory scanned by one
// comparator, one slot per cycle, and the recency list is a ring rotated
// once per cycle through its head. A get scans until a hit or the last
// slot, a miss or new page installs at the least recent slot, and each
// then turns the ring through all N slots; a release scans every slot.
// One item is in work at a time; req_ready is low until its final result
// sits in the output register. The output register lets the next item be
// accepted while that result waits. When the receiver stalls, a release
// holds its scan until the output register frees up.
// After reset all slots are unbound and clean and the recency order runs
// from slot 0 (least recent) to slot N-1; no clearing pass is needed.
`default_nettype none

`include "lru_page_cache_directory_defines.svh"

module lru_page_cache_directory #(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire lpcd_pkg::req_item_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output lpcd_pkg::rsp_item_t    rsp
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_INSTALL,
        ST_ROT,
        ST_EMIT,
        ST_REL
    } state_t;

    state_t                 state_reg, state_next;
    logic [SW-1:0]          idx_reg, idx_next;
    logic [SW-1:0]          rot_reg, rot_next;
    logic [SW-1:0]          s_reg, s_next;
    logic                   found_reg, found_next;
    logic                   fetch_reg, fetch_next;
    logic [7:0]             file_reg, file_next;
    logic [31:0]            page_reg, page_next;
    lpcd_pkg::rsp_item_t    pend_reg, pend_next;
    lpcd_pkg::rsp_item_t    out_reg, out_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_COUNT-1:0]  valid_reg, valid_next;
    logic [SLOT_COUNT-1:0]  dirty_reg, dirty_next;
    logic [SW-1:0]          order_reg [SLOT_COUNT];
    logic [SW-1:0]          order_next [SLOT_COUNT];

    lpcd_pkg::tag_t         tag_mem [SLOT_COUNT];
    lpcd_pkg::tag_t         mem_q;
    logic [SW-1:0]          rd_addr;
    logic                   mem_we;

    logic                   out_free;
    logic                   out_load;
    logic                   sel_ok;
    logic [SW-1:0]          sel_idx;
    logic [SW-1:0]          victim;
    logic                   victim_wb;
    logic                   head_is_s;
    logic [SW-1:0]          push;
    logic                   rel_match;
    logic                   advance;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign sel_ok    = 32'(req.slot_sel) < 32'(SLOT_COUNT);
    assign sel_idx   = SW'(req.slot_sel);
    assign victim    = order_reg[0];
    assign victim_wb = valid_reg[victim] && dirty_reg[victim];
    assign head_is_s = (order_reg[0] == s_reg);
    assign push      = (found_reg || head_is_s)
                     ? ((rot_reg == LAST_IDX) ? s_reg : order_reg[1])
                     : order_reg[0];
    assign rel_match = valid_reg[idx_reg] && (mem_q.file_id == file_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        rot_next       = rot_reg;
        s_next         = s_reg;
        found_next     = found_reg;
        fetch_next     = fetch_reg;
        file_next      = file_reg;
        page_next      = page_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_load       = 1'b0;
        valid_next     = valid_reg;
        dirty_next     = dirty_reg;
        order_next     = order_reg;
        rd_addr        = idx_reg;
        mem_we         = 1'b0;
        advance        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    file_next = req.file_id;
                    page_next = req.page_ref;
                    idx_next  = '0;
                    rd_addr   = '0;
                    case (req.command)
                        lpcd_pkg::CMD_GET:
                        begin
                            state_next = ST_LOOK;
                        end
                        lpcd_pkg::CMD_NEW:
                        begin
                            rd_addr    = victim;
                            fetch_next = 1'b0;
                            state_next = ST_INSTALL;
                        end
                        lpcd_pkg::CMD_DIRTY:
                        begin
                            if (sel_ok && valid_reg[sel_idx])
                            begin
                                dirty_next[sel_idx] = 1'b1;
                            end
                            pend_next      = '0;
                            pend_next.slot = req.slot_sel;
                            pend_next.last = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        lpcd_pkg::CMD_RELEASE:
                        begin
                            state_next = ST_REL;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (valid_reg[idx_reg] && mem_q.file_id == file_reg
                    && mem_q.page_ref == page_reg)
                begin
                    s_next         = idx_reg;
                    pend_next      = '0;
                    pend_next.slot = 4'(idx_reg);
                    pend_next.hit  = 1'b1;
                    pend_next.last = 1'b1;
                    rot_next       = '0;
                    found_next     = 1'b0;
                    state_next     = ST_ROT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    rd_addr    = victim;
                    fetch_next = 1'b1;
                    state_next = ST_INSTALL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    rd_addr  = idx_reg + 1'b1;
                end
            end
            ST_INSTALL:
            begin
                pend_next              = '0;
                pend_next.slot         = 4'(victim);
                pend_next.fetch_needed = fetch_reg;
                pend_next.writeback    = victim_wb;
                if (victim_wb)
                begin
                    pend_next.writeback_file = mem_q.file_id;
                    pend_next.writeback_page = mem_q.page_ref;
                end
                pend_next.last     = 1'b1;
                mem_we             = 1'b1;
                valid_next[victim] = 1'b1;
                dirty_next[victim] = 1'b0;
                s_next             = victim;
                rot_next           = '0;
                found_next         = 1'b0;
                state_next         = ST_ROT;
            end
            ST_ROT:
            begin
                for (int k = 0; k < SLOT_COUNT - 1; k++)
                begin
                    order_next[k] = order_reg[k+1];
                end
                order_next[SLOT_COUNT-1] = push;
                found_next = found_reg || head_is_s;
                rot_next   = rot_reg + 1'b1;
                if (rot_reg == LAST_IDX)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    out_load       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_REL:
            begin
                if (rel_match && dirty_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        out_next                = '0;
                        out_next.slot           = 4'(idx_reg);
                        out_next.writeback      = 1'b1;
                        out_next.writeback_file = mem_q.file_id;
                        out_next.writeback_page = mem_q.page_ref;
                        out_valid_next          = 1'b1;
                        out_load                = 1'b1;
                    end
                    else
                    begin
                        advance = 1'b0;
                    end
                end
                if (advance)
                begin
                    if (rel_match)
                    begin
                        valid_next[idx_reg] = 1'b0;
                        dirty_next[idx_reg] = 1'b0;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        pend_next      = '0;
                        pend_next.last = 1'b1;
                        state_next     = ST_EMIT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[victim] <= '{file_id: file_reg, page_ref: page_reg};
        end
        mem_q <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            rot_reg       <= '0;
            s_reg         <= '0;
            found_reg     <= 1'b0;
            fetch_reg     <= 1'b0;
            file_reg      <= '0;
            page_reg      <= '0;
            pend_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                order_reg[k] <= SW'(k);
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rot_reg       <= rot_next;
            s_reg         <= s_next;
            found_reg     <= found_next;
            fetch_reg     <= fetch_next;
            file_reg      <= file_next;
            page_reg      <= page_next;
            pend_reg      <= pend_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            order_reg     <= order_next;
        end
    end

    `LPCD_ASSERT_IMPL(a_out_no_overwrite, out_load, !out_valid_reg || rsp_ready)
    `LPCD_ASSERT_NEXT(a_install_binds, state_reg == ST_INSTALL, valid_reg[s_reg])
    `LPCD_ASSERT_IMPL(a_rot_found, state_reg == ST_ROT && rot_reg == LAST_IDX, found_reg || head_is_s)
    `LPCD_ASSERT_NEXT(a_rot_tail, state_reg == ST_ROT && rot_reg == LAST_IDX, order_reg[SLOT_COUNT-1] == $past(s_reg))

endmodule

`default_nettype wire
